// ===== sv/ife_pkg.sv =====
// Shared constants, operator codes and saturating arithmetic helpers for the
// infix four-operator evaluator. No dependencies.
`timescale 1ns / 1ps

package ife_pkg;

  localparam int NUM_WIDTH = 48;
  localparam int FRAC_BITS = 16;

  localparam int MAG_W = (NUM_WIDTH + FRAC_BITS > 2 * NUM_WIDTH) ?
                         (NUM_WIDTH + FRAC_BITS) : (2 * NUM_WIDTH);
  localparam int CNT_W = $clog2(NUM_WIDTH + FRAC_BITS);

  typedef logic signed [NUM_WIDTH-1:0] num_t;
  typedef logic [NUM_WIDTH-1:0]        mag_t;
  typedef logic [MAG_W-1:0]            wide_mag_t;

  localparam num_t NUM_MAX = {1'b0, {(NUM_WIDTH-1){1'b1}}};
  localparam num_t NUM_MIN = {1'b1, {(NUM_WIDTH-1){1'b0}}};

  localparam wide_mag_t LIM_POS = MAG_W'(mag_t'(NUM_MAX));
  localparam wide_mag_t LIM_NEG = MAG_W'(mag_t'(NUM_MAX)) + MAG_W'(1);

  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_MUL = 3'd2;
  localparam logic [2:0] ACT_DIV = 3'd3;

  localparam logic [1:0] POP_POS = 2'd0;
  localparam logic [1:0] POP_NEG = 2'd1;
  localparam logic [1:0] POP_MUL = 2'd2;
  localparam logic [1:0] POP_DIV = 2'd3;

  function automatic mag_t mag_of(input num_t v);
    mag_t m;
    m = v[NUM_WIDTH-1] ? mag_t'(-v) : mag_t'(v);
    return m;
  endfunction

  function automatic num_t sat_pack(input logic neg, input wide_mag_t mag);
    wide_mag_t lim;
    wide_mag_t m;
    mag_t      r;
    lim = neg ? LIM_NEG : LIM_POS;
    m   = (mag > lim) ? lim : mag;
    r   = m[NUM_WIDTH-1:0];
    return neg ? num_t'(-r) : num_t'(r);
  endfunction

  function automatic num_t sat_add(input num_t a, input num_t b);
    logic [NUM_WIDTH:0] s;
    num_t               r;
    s = {a[NUM_WIDTH-1], a} + {b[NUM_WIDTH-1], b};
    if (s[NUM_WIDTH] != s[NUM_WIDTH-1]) begin
      r = s[NUM_WIDTH] ? NUM_MIN : NUM_MAX;
    end else begin
      r = s[NUM_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic num_t sat_neg(input num_t a);
    return (a == NUM_MIN) ? NUM_MAX : num_t'(-a);
  endfunction

endpackage

// ===== sv/ife_mul.sv =====
// Bit-serial shift-and-add multiplier for signed fixed-point operands with a
// saturating result. Depends on ife_pkg.
`timescale 1ns / 1ps

module ife_mul (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  ife_pkg::num_t        op_a,
  input  ife_pkg::num_t        op_b,
  output logic                 done,
  output ife_pkg::num_t        result
);
  import ife_pkg::*;

  logic                     busy_r, busy_nxt;
  logic                     fin_r, fin_nxt;
  logic                     done_r, done_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     neg_r;
  mag_t                     mcand_r;
  logic [2*NUM_WIDTH-1:0]   acc_r;
  num_t                     res_r;
  logic [NUM_WIDTH:0]       part_sum;
  logic                     last;

  assign part_sum = {1'b0, acc_r[2*NUM_WIDTH-1:NUM_WIDTH]} +
                    {1'b0, (acc_r[0] ? mcand_r : mag_t'(0))};
  assign last     = (cnt_r == CNT_W'(NUM_WIDTH - 1));

  always_comb begin
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (last) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end else if (fin_r) begin
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r   <= op_a[NUM_WIDTH-1] ^ op_b[NUM_WIDTH-1];
      mcand_r <= mag_of(op_a);
      acc_r   <= {mag_t'(0), mag_of(op_b)};
    end else if (busy_r) begin
      acc_r <= {part_sum, acc_r[NUM_WIDTH-1:1]};
    end
    if (fin_r) begin
      res_r <= sat_pack(neg_r, MAG_W'(acc_r[2*NUM_WIDTH-1:FRAC_BITS]));
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

// ===== sv/ife_div.sv =====
// Bit-serial restoring divider computing (a << FRAC_BITS) / b with truncation
// toward zero and a saturating result. Depends on ife_pkg.
`timescale 1ns / 1ps

module ife_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  ife_pkg::num_t        op_a,
  input  ife_pkg::num_t        op_b,
  output logic                 done,
  output ife_pkg::num_t        result
);
  import ife_pkg::*;

  localparam int QW = NUM_WIDTH + FRAC_BITS;

  logic                 busy_r, busy_nxt;
  logic                 fin_r, fin_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 neg_r;
  mag_t                 dvsr_r;
  mag_t                 rem_r;
  logic [QW-1:0]        quo_r;
  num_t                 res_r;
  logic [NUM_WIDTH:0]   trial;
  logic [NUM_WIDTH:0]   diff;
  logic                 fits;
  logic                 last;

  assign trial = {rem_r, quo_r[QW-1]};
  assign diff  = trial - {1'b0, dvsr_r};
  assign fits  = !diff[NUM_WIDTH];
  assign last  = (cnt_r == CNT_W'(QW - 1));

  always_comb begin
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (last) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end else if (fin_r) begin
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r  <= op_a[NUM_WIDTH-1] ^ op_b[NUM_WIDTH-1];
      dvsr_r <= mag_of(op_b);
      rem_r  <= '0;
      quo_r  <= QW'(mag_of(op_a)) << FRAC_BITS;
    end else if (busy_r) begin
      rem_r <= fits ? diff[NUM_WIDTH-1:0] : trial[NUM_WIDTH-1:0];
      quo_r <= {quo_r[QW-2:0], fits};
    end
    if (fin_r) begin
      res_r <= sat_pack(neg_r, MAG_W'(quo_r));
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

// ===== sv/infix_four_op_evaluator_top.sv =====
// Top level of the infix four-operator evaluator: operator sequencing,
// running sum, product term and output register. Depends on ife_pkg,
// ife_mul and ife_div.
//
// Each input transaction carries one signed Q31.16 operand and the operator
// that follows it (add, subtract, multiply, divide, or end; codes above end
// also act as end). Multiply and divide bind tighter than add and subtract.
// An end operator produces one output transaction holding the saturated
// value of the whole expression and a divide-by-zero flag; on that flag the
// value is zero. Other operators produce no output transaction.
// One transaction is worked on at a time and in_stall stays high until it
// is finished. An operand joined by add or subtract passes through the
// apply state before the next acceptance. One joined by multiply waits for
// the bit-serial multiplier at one bit per cycle over 48 bits, then applies;
// one joined by a nonzero divisor waits for the restoring divider at one
// quotient bit per cycle over 64 bits. A zero divisor sets the flag at once.
// A result appears on out_valid the cycle after its end transaction is
// finished and is held while out_stall is high. A further input transaction
// is taken while a result waits; a second end result is held back until the
// first one has been taken.
// Reset clears the running sum, the product term, the error flag and the
// output valid flag, and the block starts a new expression.
`timescale 1ns / 1ps

module infix_four_op_evaluator_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ife_pkg::num_t        in_operand,
  input  logic [2:0]           in_action,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ife_pkg::num_t        out_value,
  output logic                 out_div_by_zero
);
  import ife_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MUL   = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_APPLY = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [2:0] act_r, act_nxt;
  num_t       term_r, term_nxt;
  num_t       sum_r, sum_nxt;
  num_t       prod_r, prod_nxt;
  logic [1:0] pend_r, pend_nxt;
  logic       err_r, err_nxt;
  logic       out_valid_r, out_valid_nxt;
  num_t       out_value_r, out_value_nxt;
  logic       out_dbz_r, out_dbz_nxt;

  logic       in_take;
  logic       mul_start, div_start;
  logic       mul_done, div_done;
  num_t       mul_res, div_res;
  logic       slot_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign mul_start = in_take && (pend_r == POP_MUL);
  assign div_start = in_take && (pend_r == POP_DIV) && (in_operand != '0);

  ife_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .op_a   (prod_r),
    .op_b   (in_operand),
    .done   (mul_done),
    .result (mul_res)
  );

  ife_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .op_a   (prod_r),
    .op_b   (in_operand),
    .done   (div_done),
    .result (div_res)
  );

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    term_nxt      = term_r;
    sum_nxt       = sum_r;
    prod_nxt      = prod_r;
    pend_nxt      = pend_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_dbz_nxt   = out_dbz_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          act_nxt = in_action;
          case (pend_r)
            POP_POS: begin
              term_nxt  = in_operand;
              state_nxt = ST_APPLY;
            end
            POP_NEG: begin
              term_nxt  = sat_neg(in_operand);
              state_nxt = ST_APPLY;
            end
            POP_MUL: begin
              state_nxt = ST_MUL;
            end
            default: begin
              if (in_operand == '0) begin
                err_nxt   = 1'b1;
                term_nxt  = prod_r;
                state_nxt = ST_APPLY;
              end else begin
                state_nxt = ST_DIV;
              end
            end
          endcase
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          term_nxt  = mul_res;
          state_nxt = ST_APPLY;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          term_nxt  = div_res;
          state_nxt = ST_APPLY;
        end
      end
      default: begin
        case (act_r)
          ACT_ADD: begin
            sum_nxt   = sat_add(sum_r, term_r);
            pend_nxt  = POP_POS;
            state_nxt = ST_IDLE;
          end
          ACT_SUB: begin
            sum_nxt   = sat_add(sum_r, term_r);
            pend_nxt  = POP_NEG;
            state_nxt = ST_IDLE;
          end
          ACT_MUL: begin
            prod_nxt  = term_r;
            pend_nxt  = POP_MUL;
            state_nxt = ST_IDLE;
          end
          ACT_DIV: begin
            prod_nxt  = term_r;
            pend_nxt  = POP_DIV;
            state_nxt = ST_IDLE;
          end
          default: begin
            if (slot_free) begin
              out_valid_nxt = 1'b1;
              out_value_nxt = err_r ? num_t'(0) : sat_add(sum_r, term_r);
              out_dbz_nxt   = err_r;
              sum_nxt       = '0;
              prod_nxt      = '0;
              pend_nxt      = POP_POS;
              err_nxt       = 1'b0;
              state_nxt     = ST_IDLE;
            end
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      prod_r      <= '0;
      pend_r      <= POP_POS;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      prod_r      <= prod_nxt;
      pend_r      <= pend_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    term_r      <= term_nxt;
    out_value_r <= out_value_nxt;
    out_dbz_r   <= out_dbz_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_div_by_zero = out_dbz_r;

endmodule
